// ===== src/crss_pkg.sv =====
// ============================================================================
// crss_pkg - shared types and constants for the chain residue sieve segment
// Beat structs, action codes, register indexes and the modular shift step.
// ============================================================================
package crss_pkg;

  // default sizes of the two stores
  localparam int MAX_LIMBS_DEF    = 512;
  localparam int SEGMENT_BITS_DEF = 1048576;

  // widths fixed by the beat and register formats
  localparam int Q_W    = 48;
  localparam int LIMB_W = 64;
  localparam int WORD_W = 64;

  // action codes
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_SIEVE = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // register indexes (byte address = 8 * index)
  localparam logic [2:0] REG_CHAIN_LENGTH    = 3'd0;
  localparam logic [2:0] REG_POWER_OFFSET    = 3'd1;
  localparam logic [2:0] REG_PRIMORIAL_PRIME = 3'd2;
  localparam logic [2:0] REG_LIMB_COUNT      = 3'd3;
  localparam logic [2:0] REG_SEGMENT_BASE    = 3'd4;
  localparam logic [2:0] REG_SEGMENT_SIZE    = 3'd5;

  // register reset values
  localparam logic [5:0]  RST_CHAIN_LENGTH    = 6'd6;
  localparam logic [12:0] RST_POWER_OFFSET    = 13'd1;
  localparam logic [15:0] RST_PRIMORIAL_PRIME = 16'd2357;
  localparam logic [9:0]  RST_LIMB_COUNT      = 10'd1;
  localparam logic [63:0] RST_SEGMENT_BASE    = 64'd1;
  localparam logic [20:0] RST_SEGMENT_SIZE    = 21'd1048576;

  typedef struct packed {
    logic [1:0]  action;
    logic [8:0]  limb_index;
    logic [63:0] limb_value;
    logic [47:0] prime_value;
    logic [13:0] word_index;
  } req_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        status;
  } rsp_t;

  // one restoring step: {quotient bit, (2*acc + b) mod m}, needs acc < m
  function automatic logic [Q_W:0] red_step(input logic [Q_W-1:0] acc,
                                            input logic b,
                                            input logic [Q_W-1:0] m);
    logic [Q_W:0] t;
    logic [Q_W:0] d;
    t = {acc, b};
    d = t - {1'b0, m};
    if (t >= {1'b0, m}) begin
      return {1'b1, d[Q_W-1:0]};
    end
    return {1'b0, t[Q_W-1:0]};
  endfunction

endpackage

// ===== src/crss_ram.sv =====
// ============================================================================
// crss_ram - generic single-clock RAM
// One write port, one read port, read data registered on read enable.
// ============================================================================
module crss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/chain_residue_sieve_segment.sv =====
// ============================================================================
// chain_residue_sieve_segment - residue-class sieve for first-kind chains
// Holds p# as 64-bit limbs and an alive bitmap; sieves one prime per beat.
// ============================================================================
// Usage:
//   req channel (valid/ready) carries one action per beat: load a limb,
//   clear the segment, sieve with one prime, or read a bitmap word.
//   rsp channel returns exactly one beat per request (read data, status).
//   Settings come through the APB port; write them only while idle.
// Steps, one request at a time:
//   load writes the limb, read fetches one bitmap word, clear fills each segment word with ones.
//   sieve: Horner over the limbs (one bit per cycle through the shared
//   restoring step), then power_offset doubling steps, then Euclid rounds
//   (48-bit shift-subtract divide with running quotient*s product),
//   then segment_base mod q, then per class one read-modify-write of one
//   bitmap RAM word per struck bit (no overlap).
//   Skipped primes finish early with status 1.
// A finished beat waits in the output register; the next request is taken
// while it waits. If the receiver stalls, the following result waits in its
// done state. Reset clears control state and settings; both RAMs keep
// contents, the bitmap must be cleared before it is read.
// ============================================================================
module chain_residue_sieve_segment import crss_pkg::*; #(
  parameter int MAX_LIMBS    = MAX_LIMBS_DEF,
  parameter int SEGMENT_BITS = SEGMENT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int ALIVE_WORDS = (SEGMENT_BITS + 63) / 64;
  localparam int LIMB_AW     = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
  localparam int WORD_AW     = (ALIVE_WORDS > 1) ? $clog2(ALIVE_WORDS) : 1;

  typedef enum logic [13:0] {
    S_IDLE  = 14'h0001,
    S_CLEAR = 14'h0002,
    S_READ  = 14'h0004,
    S_HRD   = 14'h0008,
    S_HLD   = 14'h0010,
    S_HBIT  = 14'h0020,
    S_DBL   = 14'h0040,
    S_DIV   = 14'h0080,
    S_EUP   = 14'h0100,
    S_OFF   = 14'h0200,
    S_CLS   = 14'h0400,
    S_SRD   = 14'h0800,
    S_SWR   = 14'h1000,
    S_DONE  = 14'h2000
  } state_t;

  state_t state;

  // settings
  logic [5:0]  chain_length;
  logic [12:0] power_offset;
  logic [15:0] primorial_prime;
  logic [9:0]  limb_count;
  logic [63:0] segment_base;
  logic [20:0] segment_size;

  // datapath
  logic [Q_W-1:0]     q, acc, g1, r;
  logic [63:0]        sh;
  logic [5:0]         bitcnt, ci;
  logic [LIMB_AW-1:0] ptr;
  logic [12:0]        pcnt;
  logic signed [49:0] s0, s1, pacc;
  logic [48:0]        idx;
  logic [WORD_AW-1:0] wcnt;
  logic               rd_hit;
  logic [63:0]        res_data;
  logic               res_status;

  // derived values
  logic [31:0]     nl32;
  logic [20:0]     seg_len;
  logic [15:0]     nwords;
  logic            req_fire, cfg_wr;
  logic [Q_W:0]    red_out;
  logic [Q_W-1:0]  red_mod;
  logic            red_bit;
  logic [Q_W-1:0]  r_half;
  logic signed [49:0] pacc_next;

  // RAM ports
  logic               lm_we, lm_re;
  logic [LIMB_AW-1:0] lm_waddr;
  logic [63:0]        lm_rdata;
  logic               bm_we, bm_re;
  logic [WORD_AW-1:0] bm_waddr, bm_raddr, idx_word;
  logic [63:0]        bm_wdata, bm_rdata;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // APB readback
  always_comb begin
    case (paddr[5:3])
      REG_CHAIN_LENGTH:    prdata = {58'd0, chain_length};
      REG_POWER_OFFSET:    prdata = {51'd0, power_offset};
      REG_PRIMORIAL_PRIME: prdata = {48'd0, primorial_prime};
      REG_LIMB_COUNT:      prdata = {54'd0, limb_count};
      REG_SEGMENT_BASE:    prdata = segment_base;
      REG_SEGMENT_SIZE:    prdata = {43'd0, segment_size};
      default:             prdata = 64'd0;
    endcase
  end

  // saturated limb count, segment length and word count
  assign nl32    = ({22'd0, limb_count} > 32'(MAX_LIMBS)) ? 32'(MAX_LIMBS)
                                                          : {22'd0, limb_count};
  assign seg_len = ({11'd0, segment_size} > 32'(SEGMENT_BITS)) ? 21'(SEGMENT_BITS)
                                                               : segment_size;
  assign nwords  = 16'(({1'b0, seg_len} + 22'd63) >> 6);

  // shared restoring step: mod q, or divide by g1 during Euclid
  assign red_mod = (state == S_DIV) ? g1 : q;
  assign red_bit = (state == S_DBL) ? 1'b0 : (state == S_DIV) ? sh[47] : sh[63];
  assign red_out = red_step(acc, red_bit, red_mod);

  // running quotient * s1
  assign pacc_next = {pacc[48:0], 1'b0} + (red_out[Q_W] ? s1 : 50'sd0);

  // r * (q+1)/2 mod q
  always_comb begin
    if (q[0]) begin
      r_half = r[0] ? 48'(({1'b0, r} + {1'b0, q}) >> 1) : (r >> 1);
    end else begin
      r_half = r[0] ? (q >> 1) : 48'd0;
    end
  end

  assign idx_word = idx[6 +: WORD_AW];

  // memory port muxing
  assign lm_we    = req_fire && (req.action == ACT_LOAD)
                    && ({23'd0, req.limb_index} < 32'(MAX_LIMBS));
  assign lm_waddr = LIMB_AW'(32'(req.limb_index));
  assign lm_re    = (state == S_HRD);

  assign bm_we    = (state == S_CLEAR) || (state == S_SWR);
  assign bm_waddr = (state == S_CLEAR) ? wcnt : idx_word;
  assign bm_wdata = (state == S_CLEAR) ? '1 : (bm_rdata & ~(64'd1 << idx[5:0]));
  assign bm_re    = (req_fire && (req.action == ACT_READ)) || (state == S_SRD);
  assign bm_raddr = (state == S_SRD) ? idx_word : WORD_AW'(32'(req.word_index));

  crss_ram #(.WIDTH(LIMB_W), .DEPTH(MAX_LIMBS)) u_limbs (
    .clk     (clk),
    .wr_en   (lm_we),
    .wr_addr (lm_waddr),
    .wr_data (req.limb_value),
    .rd_en   (lm_re),
    .rd_addr (ptr),
    .rd_data (lm_rdata)
  );

  crss_ram #(.WIDTH(WORD_W), .DEPTH(ALIVE_WORDS)) u_alive (
    .clk     (clk),
    .wr_en   (bm_we),
    .wr_addr (bm_waddr),
    .wr_data (bm_wdata),
    .rd_en   (bm_re),
    .rd_addr (bm_raddr),
    .rd_data (bm_rdata)
  );

  // settings registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_length    <= RST_CHAIN_LENGTH;
      power_offset    <= RST_POWER_OFFSET;
      primorial_prime <= RST_PRIMORIAL_PRIME;
      limb_count      <= RST_LIMB_COUNT;
      segment_base    <= RST_SEGMENT_BASE;
      segment_size    <= RST_SEGMENT_SIZE;
    end else if (cfg_wr) begin
      case (paddr[5:3])
        REG_CHAIN_LENGTH:    chain_length    <= pwdata[5:0];
        REG_POWER_OFFSET:    power_offset    <= pwdata[12:0];
        REG_PRIMORIAL_PRIME: primorial_prime <= pwdata[15:0];
        REG_LIMB_COUNT:      limb_count      <= pwdata[9:0];
        REG_SEGMENT_BASE:    segment_base    <= pwdata;
        REG_SEGMENT_SIZE:    segment_size    <= pwdata[20:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
      rsp.read_data <= res_data;
      rsp.status    <= res_status;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            res_data <= 64'd0;
            unique case (req.action)
              ACT_LOAD: begin
                res_status <= 1'b0;
                state      <= S_DONE;
              end
              ACT_CLEAR: begin
                res_status <= 1'b0;
                wcnt       <= '0;
                state      <= (nwords == 16'd0) ? S_DONE : S_CLEAR;
              end
              ACT_SIEVE: begin
                q   <= req.prime_value;
                acc <= '0;
                ptr <= LIMB_AW'(nl32 - 32'd1);
                if (req.prime_value < 48'd2 || req.prime_value <= {32'd0, primorial_prime}
                    || nl32 == 32'd0) begin
                  res_status <= 1'b1;
                  state      <= S_DONE;
                end else begin
                  res_status <= 1'b0;
                  state      <= S_HRD;
                end
              end
              ACT_READ: begin
                res_status <= 1'b0;
                rd_hit     <= ({18'd0, req.word_index} < 32'(ALIVE_WORDS));
                state      <= S_READ;
              end
              default: begin
                res_status <= 1'b0;
                state      <= S_DONE;
              end
            endcase
          end
        end

        // fill whole words with ones
        S_CLEAR: begin
          wcnt <= wcnt + 1'b1;
          if (16'(wcnt) == nwords - 16'd1) begin
            state <= S_DONE;
          end
        end

        S_READ: begin
          res_data <= rd_hit ? bm_rdata : 64'd0;
          state    <= S_DONE;
        end

        // Horner over limbs, top limb first, one bit per cycle
        S_HRD: state <= S_HLD;

        S_HLD: begin
          sh     <= lm_rdata;
          bitcnt <= 6'd63;
          state  <= S_HBIT;
        end

        S_HBIT: begin
          if (bitcnt != 6'd0) begin
            acc    <= red_out[Q_W-1:0];
            sh     <= {sh[62:0], 1'b0};
            bitcnt <= bitcnt - 6'd1;
          end else if (ptr != '0) begin
            acc   <= red_out[Q_W-1:0];
            ptr   <= ptr - 1'b1;
            state <= S_HRD;
          end else if (red_out[Q_W-1:0] == '0) begin
            res_status <= 1'b1;
            state      <= S_DONE;
          end else if (power_offset == 13'd0) begin
            g1     <= red_out[Q_W-1:0];
            s0     <= 50'sd0;
            s1     <= 50'sd1;
            sh     <= {16'd0, q};
            acc    <= '0;
            pacc   <= 50'sd0;
            bitcnt <= 6'd47;
            state  <= S_DIV;
          end else begin
            acc   <= red_out[Q_W-1:0];
            pcnt  <= power_offset;
            state <= S_DBL;
          end
        end

        // times 2^j mod q
        S_DBL: begin
          if (pcnt != 13'd1) begin
            acc  <= red_out[Q_W-1:0];
            pcnt <= pcnt - 13'd1;
          end else if (red_out[Q_W-1:0] == '0) begin
            res_status <= 1'b1;
            state      <= S_DONE;
          end else begin
            g1     <= red_out[Q_W-1:0];
            s0     <= 50'sd0;
            s1     <= 50'sd1;
            sh     <= {16'd0, q};
            acc    <= '0;
            pacc   <= 50'sd0;
            bitcnt <= 6'd47;
            state  <= S_DIV;
          end
        end

        // g0 / g1: remainder in acc, quotient * s1 in pacc
        S_DIV: begin
          acc    <= red_out[Q_W-1:0];
          sh     <= {sh[62:0], 1'b0};
          pacc   <= pacc_next;
          bitcnt <= bitcnt - 6'd1;
          if (bitcnt == 6'd0) begin
            state <= S_EUP;
          end
        end

        // Euclid round update
        S_EUP: begin
          s0 <= s1;
          s1 <= s0 - pacc;
          g1 <= acc;
          if (acc != '0) begin
            sh     <= {16'd0, g1};
            acc    <= '0;
            pacc   <= 50'sd0;
            bitcnt <= 6'd47;
            state  <= S_DIV;
          end else if (g1 != 48'd1) begin
            res_status <= 1'b1;
            state      <= S_DONE;
          end else begin
            r      <= s1[49] ? 48'(s1 + $signed({2'b00, q})) : s1[47:0];
            sh     <= segment_base;
            bitcnt <= 6'd63;
            state  <= S_OFF;
          end
        end

        // segment_base mod q, left in acc
        S_OFF: begin
          acc    <= red_out[Q_W-1:0];
          sh     <= {sh[62:0], 1'b0};
          bitcnt <= bitcnt - 6'd1;
          if (bitcnt == 6'd0) begin
            ci    <= 6'd0;
            state <= (chain_length == 6'd0) ? S_DONE : S_CLS;
          end
        end

        // first index of this class within the segment
        S_CLS: begin
          idx   <= (r >= acc) ? {1'b0, r - acc} : ({1'b0, r} + {1'b0, q} - {1'b0, acc});
          state <= S_SRD;
        end

        S_SRD: begin
          if (idx < {28'd0, seg_len}) begin
            state <= S_SWR;
          end else begin
            r  <= r_half;
            ci <= ci + 6'd1;
            state <= (ci == chain_length - 6'd1) ? S_DONE : S_CLS;
          end
        end

        // bit cleared in the write port, step by q
        S_SWR: begin
          idx   <= idx + {1'b0, q};
          state <= S_SRD;
        end

        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/crss_checker.sv =====
// ============================================================================
// crss_checker - port-level checks for chain_residue_sieve_segment
// Tracks outstanding beats and their actions; bound to the top level.
// ============================================================================
module crss_checker import crss_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  logic [1:0] outst;
  logic [1:0] act0, act1;
  logic       push, pop;

  assign push = req_valid && req_ready;
  assign pop  = rsp_valid && rsp_ready;

  // count of requests without a delivered response, and their actions
  always_ff @(posedge clk) begin
    if (rst) begin
      outst <= 2'd0;
    end else begin
      outst <= outst + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && (outst - {1'b0, pop} == 2'd0)) begin
      act0 <= req.action;
    end else if (pop) begin
      act0 <= act1;
    end
    if (push && (outst - {1'b0, pop} != 2'd0)) begin
      act1 <= req.action;
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response beat changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> outst != 2'd0)
    else $error("response without a request");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    push |-> outst != 2'd2)
    else $error("request taken with two beats outstanding");

  a_status_sieve: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |-> act0 == ACT_SIEVE)
    else $error("skip status on a non-sieve beat");

  a_data_read: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && act0 != ACT_READ |-> rsp.read_data == 64'd0)
    else $error("read data on a non-read beat");

endmodule

bind chain_residue_sieve_segment crss_checker u_crss_checker (.*);

// ===== sim/chain_residue_sieve_segment_test.sv =====
// ----------------------------------------------------------------------------
// chain_residue_sieve_segment_test - self-checking bench for the segment sieve
// Loads limbs, clears, sieves and reads the bitmap through the beat channels
// under random stalls, predicts every response and compares it field by field.
// ----------------------------------------------------------------------------
module chain_residue_sieve_segment_test;
  import crss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORDS      = SEGMENT_BITS_DEF / 64;
  localparam int IDLE_LIMIT = 400000;
  localparam int INIT_LIMBS = 16;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_ready;
  rsp_t        rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  chain_residue_sieve_segment uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow copy of the block state and settings
  logic [63:0]     limb_mem [MAX_LIMBS_DEF];
  logic [63:0]     alive_mem [WORDS];
  longint unsigned k_len, j_pow, p_max, n_limbs, seg_base, seg_size;

  req_t pend_q [$];
  rsp_t resp_q [$];

  bit in_taken;
  int in_gap, out_gap, hold_cycles, idle_cnt, mism, n_rsp, n_sieve, n_skip, n_read;

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---- arithmetic of one sieve step ----
  function automatic longint unsigned mul_mod(longint unsigned x, longint unsigned y,
                                              longint unsigned q);
    longint unsigned acc;
    acc = 0;
    for (int b = 47; b >= 0; b--) begin
      acc = (acc << 1) % q;
      if (y[b]) acc = (acc + x) % q;
    end
    return acc;
  endfunction

  function automatic longint unsigned inv_mod(longint unsigned x, longint unsigned q);
    longint s0, s1, sn;
    longint unsigned g0, g1, d, gn;
    s0 = 0; s1 = 1; g0 = q; g1 = x;
    while (g1 != 0) begin
      d  = g0 / g1;
      sn = s0 - longint'(d) * s1;
      gn = g0 - d * g1;
      s0 = s1; s1 = sn; g0 = g1; g1 = gn;
    end
    if (g0 != 1) return 0;
    return (s0 < 0) ? longint'(s0 + longint'(q)) : s0;
  endfunction

  function automatic longint unsigned seg_len();
    return (seg_size > SEGMENT_BITS_DEF) ? SEGMENT_BITS_DEF : seg_size;
  endfunction

  // strikes k classes; returns 1 when the prime is skipped
  function automatic bit strike_prime(longint unsigned q);
    longint unsigned acc, r, half, off, idx, n, nl;
    logic [63:0] v;
    n  = seg_len();
    nl = (n_limbs > MAX_LIMBS_DEF) ? MAX_LIMBS_DEF : n_limbs;
    if (q < 2 || q <= p_max) return 1'b1;
    acc = 0;
    for (int l = int'(nl) - 1; l >= 0; l--) begin
      v = limb_mem[l];
      for (int s = 48; s >= 0; s -= 16) acc = ((acc << 16) | ((v >> s) & 64'hFFFF)) % q;
    end
    if (acc == 0) return 1'b1;
    for (longint unsigned t = 0; t < j_pow; t++) acc = (acc * 2) % q;
    if (acc == 0) return 1'b1;
    r = inv_mod(acc, q);
    if (r == 0) return 1'b1;
    half = (q + 1) / 2;
    off  = seg_base % q;
    for (longint unsigned i = 0; i < k_len; i++) begin
      idx = (r >= off) ? r - off : r + q - off;
      for (; idx < n; idx += q) alive_mem[idx >> 6][idx & 63] = 1'b0;
      r = mul_mod(r, half, q);
    end
    return 1'b0;
  endfunction

  // expected response of one accepted request beat
  function automatic rsp_t sieve_predict(req_t b);
    rsp_t o;
    longint unsigned words;
    o = '0;
    case (b.action)
      ACT_LOAD: limb_mem[b.limb_index] = b.limb_value;
      ACT_CLEAR: begin
        words = (seg_len() + 63) / 64;
        for (longint unsigned w = 0; w < words && w < WORDS; w++) alive_mem[w] = '1;
      end
      ACT_SIEVE: begin
        o.status = strike_prime(b.prime_value);
        n_sieve++;
        if (o.status) n_skip++;
      end
      default: begin
        o.read_data = alive_mem[b.word_index];
        n_read++;
      end
    endcase
    return o;
  endfunction

  // ---- request driver ----
  always @(negedge clk) begin
    logic v;
    v = req_valid && !in_taken;
    if (!rst && !v) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pend_q.size() > 0) begin
        req <= pend_q.pop_front();
        v = 1'b1;
        in_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end
    end
    req_valid <= v;
  end

  // ---- response ready, with a long hold-off on request ----
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      rsp_ready <= 1'b0;
    end else if (rsp_valid && rsp_ready) begin
      out_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      rsp_ready <= (out_gap == 0);
    end else if (out_gap > 0) begin
      out_gap--;
      rsp_ready <= (out_gap == 0);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // ---- prediction on accepted requests, check of accepted responses ----
  always @(posedge clk) begin
    rsp_t e;
    in_taken <= req_valid && req_ready && !rst;
    if (!rst && rsp_valid && rsp_ready) begin
      n_rsp++;
      if (resp_q.size() == 0) begin
        mism++;
        if (mism <= 10) $display("unexpected response beat: data=%h status=%b",
                                 rsp.read_data, rsp.status);
      end else begin
        e = resp_q.pop_front();
        if (rsp.read_data !== e.read_data || rsp.status !== e.status) begin
          mism++;
          if (mism <= 10)
            $display("mismatch: exp data=%h status=%b, got data=%h status=%b",
                     e.read_data, e.status, rsp.read_data, rsp.status);
        end
      end
    end
    if (!rst && req_valid && req_ready) resp_q.push_back(sieve_predict(req));
  end

  // ---- watchdog on cycles without progress ----
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // ---- stimulus helpers ----
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  // beat with noise in the fields the action does not use
  function automatic req_t mk(logic [1:0] a, logic [8:0] li, logic [63:0] lv,
                              logic [47:0] q, logic [13:0] wi);
    req_t b;
    b.action = a; b.limb_index = li; b.limb_value = lv;
    b.prime_value = q; b.word_index = wi;
    return b;
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 3'b000}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      REG_CHAIN_LENGTH:    k_len    = val & 64'h3F;
      REG_POWER_OFFSET:    j_pow    = val & 64'h1FFF;
      REG_PRIMORIAL_PRIME: p_max    = val & 64'hFFFF;
      REG_LIMB_COUNT:      n_limbs  = val & 64'h3FF;
      REG_SEGMENT_BASE:    seg_base = val;
      default:             seg_size = val & 64'h1FFFFF;
    endcase
  endtask

  task automatic cfg_all(longint unsigned k, longint unsigned j, longint unsigned p,
                         longint unsigned lc, logic [63:0] base, longint unsigned sz);
    cfg_write(REG_CHAIN_LENGTH, k);
    cfg_write(REG_POWER_OFFSET, j);
    cfg_write(REG_PRIMORIAL_PRIME, p);
    cfg_write(REG_LIMB_COUNT, lc);
    cfg_write(REG_SEGMENT_BASE, base);
    cfg_write(REG_SEGMENT_SIZE, sz);
  endtask

  task automatic wait_idle();
    while (pend_q.size() > 0 || req_valid || resp_q.size() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // random mix; sieves pick primes just above p# only where the segment is short
  task automatic queue_random(int cnt, int sieve_pct);
    int sel;
    logic [47:0] q;
    for (int i = 0; i < cnt; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < sieve_pct) begin
        if (seg_len() <= 8192 && $urandom_range(0, 2) == 0)
          q = p_max + 1 + $urandom_range(0, 3000);
        else if ($urandom_range(0, 9) == 0)
          q = 48'($urandom_range(0, 4000));
        else
          q = rand48() | 48'h1_0000_0000;
        pend_q.push_back(mk(ACT_SIEVE, 9'($urandom), rand64(), q, 14'($urandom)));
      end else if (sel < sieve_pct + 15) begin
        pend_q.push_back(mk(ACT_LOAD, 9'($urandom), rand64(), rand48(), 14'($urandom)));
      end else if (sel < sieve_pct + 22) begin
        pend_q.push_back(mk(ACT_CLEAR, 9'($urandom), rand64(), rand48(), 14'($urandom)));
      end else begin
        pend_q.push_back(mk(ACT_READ, 9'($urandom), rand64(), rand48(),
                            ($urandom_range(0, 1) == 0) ? 14'($urandom_range(0, 40))
                                                        : 14'($urandom)));
      end
    end
  endtask

  // ---- test sequence ----
  initial begin
    rst = 1'b1; req_valid = 1'b0; req = '0; rsp_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_gap = 0; out_gap = 0; hold_cycles = 0; idle_cnt = 0; mism = 0;
    n_rsp = 0; n_sieve = 0; n_skip = 0; n_read = 0;
    foreach (limb_mem[i]) limb_mem[i] = '0;
    foreach (alive_mem[i]) alive_mem[i] = '0;
    k_len = RST_CHAIN_LENGTH; j_pow = RST_POWER_OFFSET; p_max = RST_PRIMORIAL_PRIME;
    n_limbs = RST_LIMB_COUNT; seg_base = RST_SEGMENT_BASE; seg_size = RST_SEGMENT_SIZE;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // full clear at reset size makes every bitmap word defined; load the low
    // limbs while the receiver holds off past the clear so the request side backs up
    hold_cycles = 20000;
    pend_q.push_back(mk(ACT_CLEAR, '0, '0, '0, '0));
    for (int i = 0; i < INIT_LIMBS; i++)
      pend_q.push_back(mk(ACT_LOAD, 9'(i),
                          (i == 0) ? 64'd30030 : (i == INIT_LIMBS - 1) ? '1 : rand64(),
                          rand48(), 14'($urandom)));
    wait_idle();

    // directed: extremes and the skip paths for small primes, zero residue and no inverse
    cfg_all(6, 1, 2357, 1, 1, 4096);
    pend_q.push_back(mk(ACT_CLEAR, '0, '0, '0, '0));
    pend_q.push_back(mk(ACT_READ, '0, '0, '0, 14'd16383));
    pend_q.push_back(mk(ACT_SIEVE, '0, '0, 48'd0, '0));
    pend_q.push_back(mk(ACT_SIEVE, '0, '0, 48'd1, '0));
    pend_q.push_back(mk(ACT_SIEVE, '0, '0, 48'd2357, '0));
    pend_q.push_back(mk(ACT_SIEVE, '0, '0, 48'd2358, '0));
    pend_q.push_back(mk(ACT_SIEVE, '0, '0, 48'd2359, '0));
    pend_q.push_back(mk(ACT_SIEVE, '0, '0, 48'd30030 * 3, '0));
    pend_q.push_back(mk(ACT_SIEVE, '0, '0, 48'hFFFF_FFFF_FFFF, '0));
    pend_q.push_back(mk(ACT_SIEVE, '0, '0, 48'hFFFF_FFFF_FFC5, '0));
    pend_q.push_back(mk(ACT_LOAD, '0, 64'd5003 * 6, '0, '0));
    pend_q.push_back(mk(ACT_SIEVE, '0, '0, 48'd5003, '0));
    pend_q.push_back(mk(ACT_LOAD, '0, '0, '0, '0));
    pend_q.push_back(mk(ACT_SIEVE, '0, '0, 48'd7919, '0));
    pend_q.push_back(mk(ACT_LOAD, '0, 64'd30030, '0, '0));
    pend_q.push_back(mk(ACT_SIEVE, '0, '0, 48'd2371, '0));
    for (int w = 0; w < 4; w++) pend_q.push_back(mk(ACT_READ, '0, '0, '0, 14'(w)));
    pend_q.push_back(mk(ACT_READ, '0, '0, '0, 14'd63));
    wait_idle();

    // chain length zero strikes nothing, p# of zero limbs skips
    cfg_all(0, 0, 2, 0, 0, 64);
    pend_q.push_back(mk(ACT_CLEAR, '0, '0, '0, '0));
    pend_q.push_back(mk(ACT_SIEVE, '0, '0, 48'd3, '0));
    wait_idle();
    cfg_write(REG_LIMB_COUNT, 1);
    pend_q.push_back(mk(ACT_SIEVE, '0, '0, 48'd17, '0));
    pend_q.push_back(mk(ACT_READ, '0, '0, '0, '0));
    wait_idle();

    // random phases across settings, extremes included
    cfg_all(32, 4096, 65535, 1, '1, 1);
    pend_q.push_back(mk(ACT_CLEAR, '0, '0, '0, '0));
    queue_random(18, 40);
    wait_idle();

    cfg_all(63, 8191, 2, 3, rand64(), 2000);
    pend_q.push_back(mk(ACT_CLEAR, '0, '0, '0, '0));
    queue_random(12, 45);
    wait_idle();
    queue_random(12, 45);
    wait_idle();

    cfg_all(1, 0, 65535, INIT_LIMBS, rand64(), 128);
    pend_q.push_back(mk(ACT_CLEAR, '0, '0, '0, '0));
    queue_random(6, 30);
    wait_idle();

    cfg_all(5, 7, 2357, 2, rand64(), 2097151);
    pend_q.push_back(mk(ACT_SIEVE, '0, '0, 48'hF000_0000_0001, '0));
    pend_q.push_back(mk(ACT_READ, '0, '0, '0, 14'd16383));
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      cfg_all($urandom_range(1, 32), $urandom_range(0, 64), $urandom_range(2, 9000),
              $urandom_range(1, 8), rand64(), $urandom_range(65, 8192));
      pend_q.push_back(mk(ACT_CLEAR, '0, '0, '0, '0));
      hold_cycles = (ph == 1) ? 200 : 0;
      queue_random(16, 40);
      wait_idle();
    end

    repeat (50) @(negedge clk);
    $display("covered %0d response beats: %0d sieve steps (%0d skipped), %0d word reads",
             n_rsp, n_sieve, n_skip, n_read);
    $display("settings swept across every register; %0d mismatches", mism);
    if (mism == 0 && resp_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
